// File: sv/mandelbrot_pixel_escape_count_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the escape-time pixel engine
// Shared property forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_PIXEL_ESCAPE_COUNT_ASSERT_SVH
`define MANDELBROT_PIXEL_ESCAPE_COUNT_ASSERT_SVH

// same-cycle implication
`define MPE_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MPE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/mpe_pkg.sv
// ----------------------------------------------------------------------------
// mpe_pkg
// Widths, reset values, state codes and controller/datapath bundles of the
// escape-time pixel engine.
// ----------------------------------------------------------------------------
package mpe_pkg;

	localparam int FRAC_BITS  = 28;
	localparam int MAX_ITER   = 1024;
	localparam int MAX_DIM    = 4096;

	localparam int COORD_W    = 32;
	localparam int ZOOM_W     = 32;
	localparam int DIM_W      = 13;
	localparam int ITER_W     = 11;
	localparam int PIX_W      = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// point and orbit width, in-range orbit width for the squaring multipliers
	localparam int CW         = FRAC_BITS + 31;
	localparam int ZW         = FRAC_BITS + 3;
	// zoom * width, divider dividend, quotients and offsets
	localparam int ZWID_W     = ZOOM_W + DIM_W;
	localparam int NUM_W      = DIM_W + FRAC_BITS + 15;
	localparam int STEP_W     = FRAC_BITS + 17;
	localparam int HALF_W_W   = FRAC_BITS + 16;
	localparam int PROD_W     = PIX_W + STEP_W;

	localparam logic signed [COORD_W-1:0] CENTER_RST = '0;
	localparam logic [ZOOM_W-1:0]         ZOOM_RST   = ZOOM_W'(65536);
	localparam logic [DIM_W-1:0]          DIM_RST    = DIM_W'(256);
	localparam logic [ITER_W-1:0]         ITER_RST   = ITER_W'(256);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X   = 3'd0,
		REG_CENTER_Y   = 3'd1,
		REG_ZOOM       = 3'd2,
		REG_WIDTH      = 3'd3,
		REG_HEIGHT     = 3'd4,
		REG_MAX_ITER   = 3'd5
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ZW,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_EDGE,
		ST_MAP,
		ST_POINT,
		ST_ITER,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		DIV_STEP,
		DIV_HALF_W,
		DIV_HALF_H
	} div_sel_t;

	typedef struct packed {
		logic     item_load;
		logic     zw_load;
		logic     div_start;
		div_sel_t div_sel;
		logic     div_capture;
		logic     edge_load;
		logic     map_load;
		logic     point_load;
		logic     iter;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic iter_done;
	} dp_status_t;

endpackage

// File: sv/mpe_div.sv
// ----------------------------------------------------------------------------
// mpe_div
// Restoring radix-2 divider, one quotient bit per cycle. Used for the pixel
// step and the half extents of the view.
// ----------------------------------------------------------------------------
`include "mandelbrot_pixel_escape_count_assert.svh"

module mpe_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [mpe_pkg::NUM_W-1:0]        dividend,
	input  logic [mpe_pkg::ZWID_W-1:0]       divisor,
	output logic                             done,
	output logic [mpe_pkg::NUM_W-1:0]        quotient
);

	localparam int NW    = mpe_pkg::NUM_W;
	localparam int DW    = mpe_pkg::ZWID_W;
	localparam int CNT_W = $clog2(NW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    rem_q;
	logic [NW-1:0]    quo_q;
	logic [DW:0]      rem_sh;
	logic [DW+1:0]    diff;
	logic             fits;

	always_comb begin
		rem_sh = {rem_q, quo_q[NW-1]};
		diff   = {1'b0, rem_sh} - {2'b00, divisor};
		fits   = !diff[DW+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend shifts out at the top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DW-1:0] : rem_sh[DW-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	`MPE_ASSERT_IMPL(a_div_start_idle, start, !busy_q, "divider started while busy")
	`MPE_ASSERT_IMPL(a_div_done_idle, done_q, !busy_q, "divider done while still busy")

endmodule

// File: sv/mpe_dp.sv
// ----------------------------------------------------------------------------
// mpe_dp
// Datapath: view setup (zoom*width, step and half extents, edges), pixel to
// point mapping and the escape iteration, one complex squaring per cycle.
// ----------------------------------------------------------------------------
`include "mandelbrot_pixel_escape_count_assert.svh"

module mpe_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mpe_pkg::dp_cmd_t                   cmd,
	output mpe_pkg::dp_status_t                status,
	input  logic [mpe_pkg::PIX_W-1:0]          column,
	input  logic [mpe_pkg::PIX_W-1:0]          row,
	input  logic signed [mpe_pkg::COORD_W-1:0] center_x,
	input  logic signed [mpe_pkg::COORD_W-1:0] center_y,
	input  logic [mpe_pkg::ZOOM_W-1:0]         zoom,
	input  logic [mpe_pkg::DIM_W-1:0]          image_width,
	input  logic [mpe_pkg::DIM_W-1:0]          image_height,
	input  logic [mpe_pkg::ITER_W-1:0]         max_iterations,
	output logic [mpe_pkg::ITER_W-1:0]         iteration_count
);

	localparam int F       = mpe_pkg::FRAC_BITS;
	localparam int CW      = mpe_pkg::CW;
	localparam int ZW      = mpe_pkg::ZW;
	localparam int NW      = mpe_pkg::NUM_W;
	localparam int DW      = mpe_pkg::ZWID_W;
	localparam int SW      = mpe_pkg::STEP_W;
	localparam int HW      = mpe_pkg::HALF_W_W;
	localparam int PW      = mpe_pkg::PROD_W;
	localparam int CO      = mpe_pkg::COORD_W;
	localparam int IW      = mpe_pkg::ITER_W;
	localparam int DIMW    = mpe_pkg::DIM_W;

	localparam logic [NW-1:0]         STEP_NUM = NW'(1) << (F + 16);
	localparam logic [NW-1:0]         HALF_NUM = NW'(1) << (F + 15);
	localparam int                    HALF_SH  = F + 15;
	localparam logic signed [CW-1:0]  SQ_LIM   = CW'(1) << (F + 1);
	localparam logic signed [CW-1:0]  SQ_NLIM  = -SQ_LIM;
	localparam logic [2*ZW:0]         ESC_THR  = (2*ZW+1)'(1) << (2*F + 2);
	localparam logic signed [2*ZW-1:0] XY_BIAS = (2*ZW)'((64'd1 << (F - 1)) - 64'd1);

	logic [mpe_pkg::PIX_W-1:0] col_q, row_q;
	logic [mpe_pkg::ZOOM_W-1:0] zm;
	logic [DIMW-1:0]           w_c, h_c;
	logic [IW-1:0]             limit;
	logic [DW-1:0]             zw_q;
	logic [NW-1:0]             num;
	logic [DW-1:0]             den;
	logic                      div_done;
	logic [NW-1:0]             quo;
	logic [SW-1:0]             step_q;
	logic [HW-1:0]             half_w_q;
	logic [NW-1:0]             half_h_q;
	logic signed [CW-1:0]      left_q, top_q;
	logic [PW-1:0]             re_off_q, im_off_q;
	logic signed [CW-1:0]      cre_q, cim_q;
	logic signed [CW-1:0]      x_q, y_q;
	logic [IW-1:0]             count_q;
	logic [IW-1:0]             iteration_count_q;

	logic signed [ZW-1:0]      xs, ys;
	logic signed [2*ZW-1:0]    xx, yy, xy, xy_adj, cross_term;
	logic [2*ZW:0]             mag2;
	logic                      big, escape;
	logic signed [CW-1:0]      x_next, y_next;

	// clamped view settings
	always_comb begin
		zm = (zoom == '0) ? mpe_pkg::ZOOM_W'(1) : zoom;
		if (image_width == '0) begin
			w_c = DIMW'(1);
		end else if (image_width > DIMW'(mpe_pkg::MAX_DIM)) begin
			w_c = DIMW'(mpe_pkg::MAX_DIM);
		end else begin
			w_c = image_width;
		end
		if (image_height == '0) begin
			h_c = DIMW'(1);
		end else if (image_height > DIMW'(mpe_pkg::MAX_DIM)) begin
			h_c = DIMW'(mpe_pkg::MAX_DIM);
		end else begin
			h_c = image_height;
		end
		limit = (max_iterations > IW'(mpe_pkg::MAX_ITER)) ? IW'(mpe_pkg::MAX_ITER)
			: max_iterations;
	end

	// divider operands
	always_comb begin
		case (cmd.div_sel)
			mpe_pkg::DIV_STEP: begin
				num = STEP_NUM;
				den = zw_q;
			end
			mpe_pkg::DIV_HALF_W: begin
				num = HALF_NUM;
				den = DW'(zm);
			end
			mpe_pkg::DIV_HALF_H: begin
				num = NW'(h_c) << HALF_SH;
				den = zw_q;
			end
			default: begin
				num = '0;
				den = zw_q;
			end
		endcase
	end

	mpe_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (num),
		.divisor  (den),
		.done     (div_done),
		.quotient (quo)
	);

	// escape test and orbit update; magnitudes above 2^(F+1) escape at once,
	// so only the low bits go through the multipliers
	always_comb begin
		xs     = x_q[ZW-1:0];
		ys     = y_q[ZW-1:0];
		xx     = xs * xs;
		yy     = ys * ys;
		xy     = xs * ys;
		big    = (x_q > SQ_LIM) || (x_q < SQ_NLIM) || (y_q > SQ_LIM) || (y_q < SQ_NLIM);
		mag2   = {1'b0, xx} + {1'b0, yy};
		escape = big || (mag2 > ESC_THR);
		// doubled cross term rounds toward zero
		xy_adj = xy + (xy[2*ZW-1] ? XY_BIAS : '0);
		cross_term = xy_adj >>> (F - 1);
		x_next = CW'(xx >>> F) - CW'(yy >>> F) + cre_q;
		y_next = CW'(cross_term) + cim_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			col_q <= column;
			row_q <= row;
		end
		if (cmd.zw_load) begin
			zw_q <= DW'(zm) * DW'(w_c);
		end
		if (cmd.div_capture) begin
			case (cmd.div_sel)
				mpe_pkg::DIV_STEP:   step_q   <= quo[SW-1:0];
				mpe_pkg::DIV_HALF_W: half_w_q <= quo[HW-1:0];
				mpe_pkg::DIV_HALF_H: half_h_q <= quo;
				default: ;
			endcase
		end
		if (cmd.edge_load) begin
			left_q <= $signed({{(CW-CO){center_x[CO-1]}}, center_x})
				- $signed({{(CW-HW){1'b0}}, half_w_q});
			top_q  <= $signed({{(CW-CO){center_y[CO-1]}}, center_y})
				+ $signed({{(CW-NW){1'b0}}, half_h_q});
		end
		if (cmd.map_load) begin
			re_off_q <= PW'(col_q) * PW'(step_q);
			im_off_q <= PW'(row_q) * PW'(step_q);
		end
		if (cmd.point_load) begin
			cre_q   <= left_q + $signed({{(CW-PW){1'b0}}, re_off_q});
			cim_q   <= top_q - $signed({{(CW-PW){1'b0}}, im_off_q});
			x_q     <= '0;
			y_q     <= '0;
			count_q <= '0;
		end else if (cmd.iter && !status.iter_done) begin
			x_q     <= x_next;
			y_q     <= y_next;
			count_q <= count_q + IW'(1);
		end
		if (cmd.out_load) begin
			iteration_count_q <= count_q;
		end
	end

	always_comb begin
		status.div_done  = div_done;
		status.iter_done = (count_q == limit) || escape;
	end

	assign iteration_count = iteration_count_q;

	`MPE_ASSERT_IMPL(a_dp_capture_done, cmd.div_capture, div_done,
		"quotient captured before the divider finished")

endmodule

// File: sv/mpe_ctrl.sv
// ----------------------------------------------------------------------------
// mpe_ctrl
// Controller: handshakes, view recompute after register writes, sequencing
// of the divider, point mapping, iteration and the output register.
// ----------------------------------------------------------------------------
`include "mandelbrot_pixel_escape_count_assert.svh"

module mpe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pixel_valid,
	output logic                pixel_ready,
	output logic                count_valid,
	input  logic                count_ready,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	output mpe_pkg::dp_cmd_t    cmd,
	input  mpe_pkg::dp_status_t status
);

	mpe_pkg::state_t   state_q, state_d;
	mpe_pkg::div_sel_t sel_q, sel_d;
	logic              dirty_q, dirty_d;
	logic              count_valid_q, count_valid_d;
	logic              cfg_wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= mpe_pkg::ST_IDLE;
			sel_q         <= mpe_pkg::DIV_STEP;
			dirty_q       <= 1'b1;
			count_valid_q <= 1'b0;
		end else begin
			state_q       <= state_d;
			sel_q         <= sel_d;
			dirty_q       <= dirty_d;
			count_valid_q <= count_valid_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		sel_d         = sel_q;
		dirty_d       = dirty_q;
		count_valid_d = count_valid_q;
		pixel_ready   = 1'b0;
		cfg_ready     = 1'b0;
		cmd           = '0;
		cmd.div_sel   = sel_q;

		if (count_valid_q && count_ready) begin
			count_valid_d = 1'b0;
		end

		cfg_ready = (state_q == mpe_pkg::ST_IDLE);
		cfg_wr    = cfg_valid && cfg_ready;
		if (cfg_wr) begin
			dirty_d = 1'b1;
		end

		case (state_q)
			mpe_pkg::ST_IDLE: begin
				pixel_ready = 1'b1;
				if (pixel_valid) begin
					cmd.item_load = 1'b1;
					// a write in the same transfer cycle also forces a recompute
					state_d = (dirty_q || cfg_wr) ? mpe_pkg::ST_ZW : mpe_pkg::ST_MAP;
				end
			end
			mpe_pkg::ST_ZW: begin
				cmd.zw_load = 1'b1;
				sel_d       = mpe_pkg::DIV_STEP;
				state_d     = mpe_pkg::ST_DIV_GO;
			end
			mpe_pkg::ST_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_d       = mpe_pkg::ST_DIV_WAIT;
			end
			mpe_pkg::ST_DIV_WAIT: begin
				if (status.div_done) begin
					cmd.div_capture = 1'b1;
					case (sel_q)
						mpe_pkg::DIV_STEP: begin
							sel_d   = mpe_pkg::DIV_HALF_W;
							state_d = mpe_pkg::ST_DIV_GO;
						end
						mpe_pkg::DIV_HALF_W: begin
							sel_d   = mpe_pkg::DIV_HALF_H;
							state_d = mpe_pkg::ST_DIV_GO;
						end
						default: begin
							state_d = mpe_pkg::ST_EDGE;
						end
					endcase
				end
			end
			mpe_pkg::ST_EDGE: begin
				cmd.edge_load = 1'b1;
				dirty_d       = 1'b0;
				state_d       = mpe_pkg::ST_MAP;
			end
			mpe_pkg::ST_MAP: begin
				cmd.map_load = 1'b1;
				state_d      = mpe_pkg::ST_POINT;
			end
			mpe_pkg::ST_POINT: begin
				cmd.point_load = 1'b1;
				state_d        = mpe_pkg::ST_ITER;
			end
			mpe_pkg::ST_ITER: begin
				cmd.iter = 1'b1;
				if (status.iter_done) begin
					state_d = mpe_pkg::ST_DONE;
				end
			end
			mpe_pkg::ST_DONE: begin
				// output register free or being emptied this cycle
				if (!count_valid_q || count_ready) begin
					cmd.out_load  = 1'b1;
					count_valid_d = 1'b1;
					state_d       = mpe_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mpe_pkg::ST_IDLE;
			end
		endcase
	end

	assign count_valid = count_valid_q;

	`MPE_ASSERT_IMPL(a_ctrl_rise_from_done, $rose(count_valid_q),
		$past(state_q) == mpe_pkg::ST_DONE, "result shown without finishing a pixel")
	`MPE_ASSERT_IMPL(a_ctrl_map_clean, state_q == mpe_pkg::ST_MAP, !dirty_q,
		"pixel mapped with a stale view")

endmodule

// File: sv/mandelbrot_pixel_escape_count.sv
// ----------------------------------------------------------------------------
// mandelbrot_pixel_escape_count
// Escape-time engine: maps a pixel to a point c of the configured view and
// counts iterations of z = z*z + c from zero until |z|^2 exceeds 4 or the
// iteration limit is reached. One pixel is in flight at a time; the orbit
// loop does one complex squaring per cycle. Besides its iterations, a
// pixel passes through transfer, mapping, point add, a final escape
// check and the output load. The view's step and half extents come
// from a one-bit-per-cycle divider and are redone only for the first
// pixel after reset or a register write, which adds three divisions
// plus the zoom*width and edge steps to that pixel. A finished count
// waits in an output register while the next pixel is taken in.
// Registers are written only while the engine is idle.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_escape_count (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mpe_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mpe_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                pixel_valid,
	output logic                                pixel_ready,
	input  logic [mpe_pkg::PIX_W-1:0]           column,
	input  logic [mpe_pkg::PIX_W-1:0]           row,
	output logic                                count_valid,
	input  logic                                count_ready,
	output logic [mpe_pkg::ITER_W-1:0]          iteration_count
);

	logic signed [mpe_pkg::COORD_W-1:0] center_x_q, center_y_q;
	logic [mpe_pkg::ZOOM_W-1:0]         zoom_q;
	logic [mpe_pkg::DIM_W-1:0]          image_width_q, image_height_q;
	logic [mpe_pkg::ITER_W-1:0]         max_iterations_q;
	mpe_pkg::dp_cmd_t                   cmd;
	mpe_pkg::dp_status_t                status;

	// register file; writes to unused indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q       <= mpe_pkg::CENTER_RST;
			center_y_q       <= mpe_pkg::CENTER_RST;
			zoom_q           <= mpe_pkg::ZOOM_RST;
			image_width_q    <= mpe_pkg::DIM_RST;
			image_height_q   <= mpe_pkg::DIM_RST;
			max_iterations_q <= mpe_pkg::ITER_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (mpe_pkg::cfg_reg_t'(cfg_index))
				mpe_pkg::REG_CENTER_X: center_x_q <= cfg_data[mpe_pkg::COORD_W-1:0];
				mpe_pkg::REG_CENTER_Y: center_y_q <= cfg_data[mpe_pkg::COORD_W-1:0];
				mpe_pkg::REG_ZOOM:     zoom_q     <= cfg_data[mpe_pkg::ZOOM_W-1:0];
				mpe_pkg::REG_WIDTH:    image_width_q  <= cfg_data[mpe_pkg::DIM_W-1:0];
				mpe_pkg::REG_HEIGHT:   image_height_q <= cfg_data[mpe_pkg::DIM_W-1:0];
				mpe_pkg::REG_MAX_ITER: max_iterations_q <= cfg_data[mpe_pkg::ITER_W-1:0];
				default: ;
			endcase
		end
	end

	mpe_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.count_valid (count_valid),
		.count_ready (count_ready),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cmd         (cmd),
		.status      (status)
	);

	mpe_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.column          (column),
		.row             (row),
		.center_x        (center_x_q),
		.center_y        (center_y_q),
		.zoom            (zoom_q),
		.image_width     (image_width_q),
		.image_height    (image_height_q),
		.max_iterations  (max_iterations_q),
		.iteration_count (iteration_count)
	);

endmodule
